// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checked natural ALU modules.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CNA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CNA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cna_pkg.sv =====
// Types and constants of the checked natural ALU.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cna_pkg;

  localparam int NAT_W       = 63;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    MODE_INC = 4'd0,
    MODE_ADD = 4'd1,
    MODE_SUB = 4'd2,
    MODE_MUL = 4'd3,
    MODE_DIV = 4'd4,
    MODE_MOD = 4'd5,
    MODE_EQ  = 4'd6,
    MODE_NE  = 4'd7,
    MODE_LT  = 4'd8,
    MODE_GT  = 4'd9,
    MODE_LE  = 4'd10,
    MODE_GE  = 4'd11
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2,
    KIND_MOD    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [3:0]       mode;
    logic [NAT_W-1:0] left_operand;
    logic [NAT_W-1:0] right_operand;
  } in_t;

  typedef struct packed {
    logic [NAT_W-1:0] result_value;
    logic             is_boolean;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic [NAT_W-1:0] value;
    logic             is_boolean;
    status_e          status;
  } res_t;

  // Queue entry: classified operation with operands already masked.
  typedef struct packed {
    kind_e            kind;
    logic             b_zero;
    logic [NAT_W-1:0] a;
    logic [NAT_W-1:0] b;
    res_t             res;
  } entry_t;

endpackage

// ===== rtl/checked_natural_alu_core.sv =====
// Checked natural ALU. One transaction is accepted every cycle while the queue is not full
// (in_stall_o low); a stalled output holds the pipeline and so lets the queue fill.
// The pipeline depth is set by the divider, one quotient bit per pipeline stage.
// Reset clears the queue and all pipeline valid bits; no result is pending after reset.
// Depends on cna_pkg, cna_front, cna_fifo and cna_back.
`timescale 1ns / 1ps
module checked_natural_alu_core import cna_pkg::*; #(
  parameter int VALUE_WIDTH = 63
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  entry_t entry, head;
  logic   push, pop, empty, full;

  cna_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (entry)
  );

  cna_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  cna_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/cna_front.sv =====
// Front end: accepts transactions, classifies them and settles the short operations.
// Depends on cna_pkg.
`timescale 1ns / 1ps
module cna_front import cna_pkg::*; #(
  parameter int VALUE_WIDTH = 63
) (
  input  logic   in_valid_i,
  input  in_t    in_data_i,
  input  logic   full_i,
  output logic   in_stall_o,
  output logic   push_o,
  output entry_t entry_o
);

  localparam int W = VALUE_WIDTH;

  logic [W-1:0] a, b;
  logic [W:0]   inc_s, add_s, sub_s;
  logic         eq, lt;
  res_t         res;
  kind_e        kind;

  assign a     = in_data_i.left_operand[W-1:0];
  assign b     = in_data_i.right_operand[W-1:0];
  assign inc_s = {1'b0, a} + {{W{1'b0}}, 1'b1};
  assign add_s = {1'b0, a} + {1'b0, b};
  assign sub_s = {1'b0, a} - {1'b0, b};
  assign eq    = (a == b);
  assign lt    = sub_s[W];

  always_comb begin
    res  = '{value: '0, is_boolean: 1'b0, status: ST_OK};
    kind = KIND_SIMPLE;
    case (in_data_i.mode)
      MODE_INC: begin
        if (inc_s[W]) res.status = ST_OVERFLOW;
        else res.value = NAT_W'(inc_s[W-1:0]);
      end
      MODE_ADD: begin
        if (add_s[W]) res.status = ST_OVERFLOW;
        else res.value = NAT_W'(add_s[W-1:0]);
      end
      MODE_SUB: begin
        if (sub_s[W]) res.status = ST_UNDERFLOW;
        else res.value = NAT_W'(sub_s[W-1:0]);
      end
      MODE_MUL: kind = KIND_MUL;
      MODE_DIV: kind = KIND_DIV;
      MODE_MOD: kind = KIND_MOD;
      MODE_EQ: begin
        res.is_boolean = 1'b1;
        res.value      = NAT_W'(eq);
      end
      MODE_NE: begin
        res.is_boolean = 1'b1;
        res.value      = NAT_W'(!eq);
      end
      MODE_LT: begin
        res.is_boolean = 1'b1;
        res.value      = NAT_W'(lt);
      end
      MODE_GT: begin
        res.is_boolean = 1'b1;
        res.value      = NAT_W'(!lt && !eq);
      end
      MODE_LE: begin
        res.is_boolean = 1'b1;
        res.value      = NAT_W'(lt || eq);
      end
      MODE_GE: begin
        res.is_boolean = 1'b1;
        res.value      = NAT_W'(!lt);
      end
      default: ;
    endcase
  end

  assign in_stall_o     = full_i;
  assign push_o         = in_valid_i && !full_i;
  assign entry_o.kind   = kind;
  assign entry_o.b_zero = (b == '0);
  assign entry_o.a      = NAT_W'(a);
  assign entry_o.b      = NAT_W'(b);
  assign entry_o.res    = res;

endmodule

// ===== rtl/cna_fifo.sv =====
// Short queue between the front end and the execution pipeline.
// Depends on cna_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cna_fifo import cna_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  `CNA_ASSERT(a_fifo_bound, clk_i, rst_ni, cnt_q <= CW'(QUEUE_DEPTH), "queue count past depth")
  `CNA_ASSERT(a_fifo_pop, clk_i, rst_ni, pop_i |-> !empty_o, "pop from empty queue")

endmodule

// ===== rtl/cna_back.sv =====
// Execution pipeline: radix-2 restoring divider stages with a split multiplier alongside,
// and the output register. Depends on cna_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cna_back import cna_pkg::*; #(
  parameter int VALUE_WIDTH = 63
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   empty_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output out_t   out_data_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;

  typedef struct packed {
    logic         vld;
    kind_e        kind;
    logic         b_zero;
    res_t         res;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] b;
  } stage_t;

  stage_t st_q [W];
  stage_t st_in [W];
  stage_t st_d [W];

  logic adv;
  logic out_vld_q;
  out_t out_q, out_d;
  logic err_out, bool_out;

  // The whole pipeline moves together whenever the output register can take a value.
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  // Multiplier: four partial products, then the cross sum, then the full product.
  logic [2*LO-1:0] pll_q, pll2_q;
  logic [W-1:0]    plh_q, phl_q;
  logic [2*HI-1:0] phh_q, phh2_q;
  logic [W:0]      cross_q;
  logic [2*W-1:0]  prod_q;
  logic            mul_ovf;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pll_q   <= head_i.a[LO-1:0] * head_i.b[LO-1:0];
      plh_q   <= W'(head_i.a[LO-1:0] * head_i.b[W-1:LO]);
      phl_q   <= W'(head_i.a[W-1:LO] * head_i.b[LO-1:0]);
      phh_q   <= head_i.a[W-1:LO] * head_i.b[W-1:LO];
      pll2_q  <= pll_q;
      phh2_q  <= phh_q;
      cross_q <= {1'b0, plh_q} + {1'b0, phl_q};
      prod_q  <= (2*W)'(pll2_q) + ((2*W)'(cross_q) << LO) + ((2*W)'(phh2_q) << (2*LO));
    end
  end

  assign mul_ovf = |prod_q[2*W-1:W];

  always_comb begin
    st_in[0].vld    = pop_o;
    st_in[0].kind   = head_i.kind;
    st_in[0].b_zero = head_i.b_zero;
    st_in[0].res    = head_i.res;
    st_in[0].rem    = '0;
    st_in[0].quo    = head_i.a[W-1:0];
    st_in[0].b      = head_i.b[W-1:0];
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    if (s > 0 && s != 3) begin : g_link
      assign st_in[s] = st_q[s-1];
    end else if (s == 3) begin : g_merge
      // The product is ready as the transaction enters this stage.
      always_comb begin
        st_in[s] = st_q[s-1];
        if (st_q[s-1].kind == KIND_MUL) begin
          st_in[s].res.is_boolean = 1'b0;
          st_in[s].res.status     = mul_ovf ? ST_OVERFLOW : ST_OK;
          st_in[s].res.value      = mul_ovf ? '0 : NAT_W'(prod_q[W-1:0]);
        end
      end
    end

    logic [W:0] trial;
    logic       ge;

    // One quotient bit per stage: shift the next dividend bit in, subtract if it fits.
    assign trial = {st_in[s].rem, st_in[s].quo[W-1]};
    assign ge    = (trial >= {1'b0, st_in[s].b});

    always_comb begin
      st_d[s]     = st_in[s];
      st_d[s].rem = ge ? W'(trial - {1'b0, st_in[s].b}) : trial[W-1:0];
      st_d[s].quo = {st_in[s].quo[W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[s] <= '0;
      end else if (adv) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // A zero divisor leaves the dividend in the remainder, which is what modulo wants.
  always_comb begin
    out_d.result_value = st_q[W-1].res.value;
    out_d.is_boolean   = st_q[W-1].res.is_boolean;
    out_d.status       = st_q[W-1].res.status;
    case (st_q[W-1].kind)
      KIND_DIV: begin
        out_d.is_boolean = 1'b0;
        if (st_q[W-1].b_zero) begin
          out_d.result_value = '0;
          out_d.status       = ST_DIVZERO;
        end else begin
          out_d.result_value = NAT_W'(st_q[W-1].quo);
          out_d.status       = ST_OK;
        end
      end
      KIND_MOD: begin
        out_d.is_boolean   = 1'b0;
        out_d.result_value = NAT_W'(st_q[W-1].rem);
        out_d.status       = ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= st_q[W-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign err_out  = out_vld_q && (out_q.status != ST_OK);
  assign bool_out = out_vld_q && out_q.is_boolean;

  `CNA_ASSERT(a_err_zero, clk_i, rst_ni, err_out |-> (out_q.result_value == '0), "error result not zero")
  `CNA_ASSERT(a_bool_bit, clk_i, rst_ni, bool_out |-> (out_q.result_value[NAT_W-1:1] == '0), "wide boolean")

endmodule

// ===== tb/tb_checked_natural_alu_core.sv =====
// Self-checking testbench for checked_natural_alu_core: directed corner cases, then random
// transactions with random idling on both sides. Depends on cna_pkg and the RTL top level.
`timescale 1ns / 1ps

// Holds the results still owed by the ALU, oldest first, and compares arriving results.
class alu_result_book;
  cna_pkg::out_t owed[$];
  int            errors;

  function new();
    errors = 0;
  endfunction

  // Reckons the result of one operation at the default width.
  static function cna_pkg::out_t compute(cna_pkg::in_t op);
    localparam logic [62:0] NAT_MAX = {63{1'b1}};
    cna_pkg::out_t   r;
    logic [62:0]     a;
    logic [62:0]     b;
    logic [63:0]     sum;
    logic [125:0]    prod;
    a = op.left_operand;
    b = op.right_operand;
    r = '0;
    r.status = cna_pkg::ST_OK;
    sum = {1'b0, a} + {1'b0, b};
    prod = a * b;
    case (op.mode)
      cna_pkg::MODE_INC: begin
        if (a == NAT_MAX) r.status = cna_pkg::ST_OVERFLOW;
        else r.result_value = a + 63'd1;
      end
      cna_pkg::MODE_ADD: begin
        if (sum[63]) r.status = cna_pkg::ST_OVERFLOW;
        else r.result_value = sum[62:0];
      end
      cna_pkg::MODE_SUB: begin
        if (b > a) r.status = cna_pkg::ST_UNDERFLOW;
        else r.result_value = a - b;
      end
      cna_pkg::MODE_MUL: begin
        if (prod > {63'd0, NAT_MAX}) r.status = cna_pkg::ST_OVERFLOW;
        else r.result_value = prod[62:0];
      end
      cna_pkg::MODE_DIV: begin
        if (b == '0) r.status = cna_pkg::ST_DIVZERO;
        else r.result_value = a / b;
      end
      cna_pkg::MODE_MOD: r.result_value = (b == '0) ? a : a % b;
      cna_pkg::MODE_EQ: begin r.result_value = 63'(a == b); r.is_boolean = 1'b1; end
      cna_pkg::MODE_NE: begin r.result_value = 63'(a != b); r.is_boolean = 1'b1; end
      cna_pkg::MODE_LT: begin r.result_value = 63'(a < b);  r.is_boolean = 1'b1; end
      cna_pkg::MODE_GT: begin r.result_value = 63'(a > b);  r.is_boolean = 1'b1; end
      cna_pkg::MODE_LE: begin r.result_value = 63'(a <= b); r.is_boolean = 1'b1; end
      cna_pkg::MODE_GE: begin r.result_value = 63'(a >= b); r.is_boolean = 1'b1; end
      default: ;
    endcase
    return r;
  endfunction

  function void note_operation(cna_pkg::in_t op);
    owed.push_back(compute(op));
  endfunction

  function void check_result(cna_pkg::out_t got);
    cna_pkg::out_t want;
    if (owed.size() == 0) begin
      $display("%0t: unexpected result value=%h bool=%b status=%0d", $time,
               got.result_value, got.is_boolean, got.status);
      errors++;
      return;
    end
    want = owed.pop_front();
    if (got.result_value !== want.result_value) begin
      $display("%0t: result_value expected %h actual %h", $time, want.result_value,
               got.result_value);
      errors++;
    end
    if (got.is_boolean !== want.is_boolean) begin
      $display("%0t: is_boolean expected %b actual %b", $time, want.is_boolean,
               got.is_boolean);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_checked_natural_alu_core;
  import cna_pkg::*;

  localparam logic [62:0] NAT_MAX = {63{1'b1}};
  localparam int          LATENCY = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  alu_result_book book = new();
  bit             hold_off_request = 1'b0;
  bit             quiet_sink = 1'b0;

  checked_natural_alu_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) book.note_operation(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) book.check_result(out_data_o);
  end

  // Receiver: random stalls, bursts without any, and one long hold-off on request.
  initial begin
    int stall_left;
    int open_left;
    stall_left = 0;
    open_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (open_left > 0 || quiet_sink) begin
        out_stall_i <= 1'b0;
        if (open_left > 0) open_left--;
      end else begin
        out_stall_i <= 1'b0;
        case ($urandom_range(0, 9))
          0, 1, 2: stall_left = $urandom_range(1, 3);
          3:       stall_left = $urandom_range(10, 40);
          4, 5:    open_left = $urandom_range(20, 60);
          default: ;
        endcase
      end
    end
  end

  function automatic logic [62:0] rand_nat();
    logic [62:0] v;
    int          w;
    v = 63'({$urandom(), $urandom()});
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = NAT_MAX - 63'($urandom_range(0, 3));
      2:       v = 63'($urandom_range(0, 9));
      3:       v = 63'd1 << $urandom_range(0, 62);
      4: begin
        w = $urandom_range(1, 62);
        v = v & ((63'd1 << w) - 63'd1);
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_t random_operation();
    in_t op;
    int  w;
    op.mode = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 15) < 14) op.mode = 4'($urandom_range(0, 11));
    op.left_operand = rand_nat();
    op.right_operand = rand_nat();
    if (op.mode == MODE_MUL && $urandom_range(0, 1)) begin
      // operand widths that put the product near the overflow boundary
      w = $urandom_range(1, 62);
      op.left_operand = 63'({$urandom(), $urandom()}) & ((63'd1 << w) - 63'd1);
      op.right_operand = 63'({$urandom(), $urandom()}) &
                         ((63'd1 << (63 - w + $urandom_range(0, 1))) - 63'd1);
    end else if ($urandom_range(0, 7) == 0) begin
      op.right_operand = op.left_operand;
    end
    return op;
  endfunction

  // Offers one transaction until it is taken, then idles for gap_after, if any.
  task automatic offer(in_t op, int gap_after);
    in_valid_i <= 1'b1;
    in_data_i <= op;
    do @(posedge clk_i); while (in_stall_o);
    if (gap_after > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_after) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.owed.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_t make_op(mode_e m, logic [62:0] a, logic [62:0] b);
    in_t op;
    op.mode = m;
    op.left_operand = a;
    op.right_operand = b;
    return op;
  endfunction

  initial begin
    in_t directed[$];
    in_t op;
    int  gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_op(MODE_INC, NAT_MAX, NAT_MAX));
    directed.push_back(make_op(MODE_INC, '0, '0));
    directed.push_back(make_op(MODE_ADD, NAT_MAX, '0));
    directed.push_back(make_op(MODE_ADD, NAT_MAX, 63'd1));
    directed.push_back(make_op(MODE_ADD, NAT_MAX, NAT_MAX));
    directed.push_back(make_op(MODE_SUB, '0, 63'd1));
    directed.push_back(make_op(MODE_SUB, NAT_MAX, NAT_MAX));
    directed.push_back(make_op(MODE_MUL, NAT_MAX, 63'd1));
    directed.push_back(make_op(MODE_MUL, 63'd1 << 32, 63'd1 << 31));
    directed.push_back(make_op(MODE_MUL, '0, NAT_MAX));
    directed.push_back(make_op(MODE_DIV, NAT_MAX, '0));
    directed.push_back(make_op(MODE_DIV, NAT_MAX, 63'd1));
    directed.push_back(make_op(MODE_DIV, 63'd7, NAT_MAX));
    directed.push_back(make_op(MODE_MOD, NAT_MAX, '0));
    directed.push_back(make_op(MODE_MOD, NAT_MAX, 63'd10));
    directed.push_back(make_op(MODE_EQ, NAT_MAX, NAT_MAX));
    directed.push_back(make_op(MODE_NE, NAT_MAX, '0));
    directed.push_back(make_op(MODE_LT, '0, NAT_MAX));
    directed.push_back(make_op(MODE_GT, '0, NAT_MAX));
    directed.push_back(make_op(MODE_LE, 63'd5, 63'd5));
    directed.push_back(make_op(MODE_GE, '0, 63'd1));
    for (int m = 12; m < 16; m++) begin
      op = make_op(MODE_INC, NAT_MAX, NAT_MAX);
      op.mode = 4'(m);
      directed.push_back(op);
    end
    foreach (directed[i]) offer(directed[i], 0);
    drain();

    // Receiver holds off for a long stretch while transactions keep coming.
    quiet_sink = 1'b0;
    hold_off_request = 1'b1;
    for (int i = 0; i < 150; i++) offer(random_operation(), 0);
    drain();

    for (int i = 0; i < 700; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
      offer(random_operation(), gap);
      if (i == 350) begin
        drain();
        quiet_sink = 1'b1;
      end else if (i == 500) begin
        quiet_sink = 1'b0;
      end
    end
    drain();
    repeat (LATENCY + 16) @(posedge clk_i);

    if (book.errors == 0) begin
      $display("tb_checked_natural_alu_core: PASS");
    end else begin
      $display("tb_checked_natural_alu_core: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_checked_natural_alu_core: FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cna_pkg.sv
rtl/cna_front.sv
rtl/cna_fifo.sv
rtl/cna_back.sv
rtl/checked_natural_alu_core.sv
tb/tb_checked_natural_alu_core.sv
